/* design/dcnd_pkg.sv */
// Shared types and codes for the dual-processor bus decoder.
// Used by the front decoder, the command queue, the back end and the top level.
package dcnd_pkg;

	// access kinds carried in the input tuser
	localparam logic [1:0] MODE_MAIN_WR = 2'd0;
	localparam logic [1:0] MODE_MAIN_RD = 2'd1;
	localparam logic [1:0] MODE_SND_WR  = 2'd2;
	localparam logic [1:0] MODE_SND_RD  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_SW_A = 2'd0;
	localparam logic [1:0] CFG_SW_B = 2'd1;
	localparam logic [1:0] CFG_SW_C = 2'd2;

	localparam logic [7:0] SW_A_RESET = 8'h6f;
	localparam logic [7:0] SW_B_RESET = 8'h00;
	localparam logic [7:0] SW_C_RESET = 8'hdc;

	// sound chip kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_AY   = 2'd1;
	localparam logic [1:0] KIND_MSM  = 2'd2;

	// bus map
	localparam logic [15:0] ADDR_PAL      = 16'hd800;
	localparam logic [15:0] ADDR_CTRL     = 16'hd100;
	localparam logic [15:0] ADDR_BANK     = 16'hd200;
	localparam logic [15:0] ADDR_SCROLL   = 16'hd300;
	localparam logic [15:0] ADDR_MCU      = 16'hd400;
	localparam logic [15:0] ADDR_MCU_ST   = 16'hd401;
	localparam logic [15:0] ADDR_SWITCH   = 16'hd600;
	localparam logic [15:0] ADDR_PLAYER   = 16'hd604;
	localparam logic [15:0] ADDR_LATCH    = 16'hd610;
	localparam logic [15:0] ADDR_MSM      = 16'hc900;
	localparam logic [15:0] ADDR_AY       = 16'hc800;
	localparam logic [15:0] ADDR_SND_LAT  = 16'hd000;
	localparam logic [15:0] ADDR_NMI_EN   = 16'hd200;
	localparam logic [15:0] ADDR_NMI_DIS  = 16'hd400;

	localparam logic [7:0] MCU_MASK     = 8'h73;
	localparam logic [7:0] MCU_ANSWER   = 8'h42;
	localparam logic [7:0] MCU_STATUS   = 8'h03;
	localparam logic [7:0] LOCKOUT_MASK = 8'hcf;
	localparam logic [7:0] AY_QUIET_KEY = 8'h88;
	localparam logic [7:0] AY_VOL_REG   = 8'h08;
	localparam logic [2:0] QUIET_LAST   = 3'd5;

	// palette store: 1024 bytes kept as 512 rows of an even/odd byte pair
	localparam int PAL_ROWS = 512;
	localparam int PAL_AW   = 9;

	// command codes passed from front to back
	localparam logic [4:0] OP_NOP       = 5'd0;
	localparam logic [4:0] OP_PAL_WR    = 5'd1;
	localparam logic [4:0] OP_PAL_RD    = 5'd2;
	localparam logic [4:0] OP_CTRL      = 5'd3;
	localparam logic [4:0] OP_BANK      = 5'd4;
	localparam logic [4:0] OP_SCROLL    = 5'd5;
	localparam logic [4:0] OP_MCU_WR    = 5'd6;
	localparam logic [4:0] OP_LATCH_NMI = 5'd7;
	localparam logic [4:0] OP_RD_IMM    = 5'd8;
	localparam logic [4:0] OP_RD_MCU    = 5'd9;
	localparam logic [4:0] OP_RD_SW     = 5'd10;
	localparam logic [4:0] OP_RD_SYS    = 5'd11;
	localparam logic [4:0] OP_RD_LATCH  = 5'd12;
	localparam logic [4:0] OP_MSM       = 5'd13;
	localparam logic [4:0] OP_AY        = 5'd14;
	localparam logic [4:0] OP_AY_QUIET  = 5'd15;
	localparam logic [4:0] OP_SND_LATCH = 5'd16;
	localparam logic [4:0] OP_NMI_EN    = 5'd17;
	localparam logic [4:0] OP_NMI_DIS   = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic [9:0] arg;   // byte address, register number or selector
		logic [7:0] data;  // write byte, or an immediate read value
	} cmd_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic        sound_nmi;
		logic        palette_write;
		logic [8:0]  palette_entry;
		logic [11:0] palette_color;
		logic [7:0]  control_value;
		logic [2:0]  program_bank;
		logic [31:0] scroll_word;
		logic [1:0]  chip_kind;
		logic [3:0]  chip_register;
		logic [7:0]  chip_data;
		logic        last_result;
	} res_t;

endpackage

/* design/dcnd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dcnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/dcnd_front.sv */
// Front end: accepts bus access words and classifies them into commands.
// Depends on dcnd_pkg.
module dcnd_front (
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,
	input  logic [1:0]        s_axis_tuser,
	input  logic              q_ready,
	input  logic              clearing,
	output logic              push,
	output dcnd_pkg::cmd_t    cmd
);
	import dcnd_pkg::*;

	logic [15:0] addr;
	logic [7:0]  data;
	logic [7:0]  p_sys;
	logic [7:0]  p_stick1;
	logic [7:0]  p_btn1;
	logic [7:0]  p_stick2;
	logic [7:0]  p_btn2;

	assign addr     = s_axis_tdata[15:0];
	assign data     = s_axis_tdata[23:16];
	assign p_sys    = s_axis_tdata[31:24];
	assign p_stick1 = s_axis_tdata[39:32];
	assign p_btn1   = s_axis_tdata[47:40];
	assign p_stick2 = s_axis_tdata[55:48];
	assign p_btn2   = s_axis_tdata[63:56];

	// hold off while the palette store is being cleared
	assign s_axis_tready = q_ready && !clearing;
	assign push          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_NOP;
		cmd.data = data;
		unique case (s_axis_tuser)
			MODE_MAIN_WR: begin
				if (addr[15:10] == ADDR_PAL[15:10]) begin
					cmd.op  = OP_PAL_WR;
					cmd.arg = addr[9:0];
				end else if (addr == ADDR_CTRL) begin
					cmd.op = OP_CTRL;
				end else if (addr == ADDR_BANK) begin
					cmd.op = OP_BANK;
				end else if (addr[15:2] == ADDR_SCROLL[15:2]) begin
					cmd.op  = OP_SCROLL;
					cmd.arg = {8'd0, addr[1:0]};
				end else if (addr == ADDR_MCU) begin
					cmd.op = OP_MCU_WR;
				end else if (addr == ADDR_LATCH) begin
					cmd.op = OP_LATCH_NMI;
				end
			end
			MODE_MAIN_RD: begin
				if (addr[15:10] == ADDR_PAL[15:10]) begin
					cmd.op  = OP_PAL_RD;
					cmd.arg = addr[9:0];
				end else if (addr == ADDR_MCU) begin
					cmd.op = OP_RD_MCU;
				end else if (addr == ADDR_MCU_ST) begin
					cmd.op   = OP_RD_IMM;
					cmd.data = MCU_STATUS;
				end else if (addr[15:2] == ADDR_SWITCH[15:2]) begin
					// the top slot of the switch group is the system port
					if (addr[1:0] == 2'd3) begin
						cmd.op   = OP_RD_SYS;
						cmd.data = p_sys;
					end else begin
						cmd.op  = OP_RD_SW;
						cmd.arg = {8'd0, addr[1:0]};
					end
				end else if (addr[15:2] == ADDR_PLAYER[15:2]) begin
					cmd.op = OP_RD_IMM;
					case (addr[1:0])
						2'd0:    cmd.data = p_stick1;
						2'd1:    cmd.data = p_btn1;
						2'd2:    cmd.data = p_stick2;
						default: cmd.data = p_btn2;
					endcase
				end else if (addr == ADDR_LATCH) begin
					cmd.op = OP_RD_LATCH;
				end else begin
					cmd.op   = OP_RD_IMM;
					cmd.data = '0;
				end
			end
			MODE_SND_WR: begin
				if (addr[15:4] == ADDR_MSM[15:4]) begin
					cmd.op  = OP_MSM;
					cmd.arg = {6'd0, addr[3:0]};
				end else if (addr[15:2] == ADDR_AY[15:2]) begin
					cmd.op  = (data == AY_QUIET_KEY) ? OP_AY_QUIET : OP_AY;
					cmd.arg = {8'd0, addr[1:0]};
				end else if (addr == ADDR_SND_LAT) begin
					cmd.op = OP_SND_LATCH;
				end else if (addr == ADDR_NMI_EN) begin
					cmd.op = OP_NMI_EN;
				end else if (addr == ADDR_NMI_DIS) begin
					cmd.op = OP_NMI_DIS;
				end
			end
			MODE_SND_RD: begin
				if (addr == ADDR_SND_LAT) begin
					cmd.op = OP_RD_LATCH;
				end else begin
					cmd.op   = OP_RD_IMM;
					cmd.data = '0;
				end
			end
			default: cmd.op = OP_NOP;
		endcase
	end

endmodule

/* design/dcnd_queue.sv */
// Two-entry command queue between the front decoder and the back end.
// Depends on dcnd_pkg.
module dcnd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dcnd_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output dcnd_pkg::cmd_t head
);
	import dcnd_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* design/dcnd_back.sv */
// Back end: holds the board registers and palette store, executes commands
// and drives the result register. Depends on dcnd_pkg and dcnd_ram.
module dcnd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  dcnd_pkg::cmd_t q_cmd,
	output logic           pop,
	output logic           clearing,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           out_ready,
	output logic           out_valid,
	output dcnd_pkg::res_t out_res
);
	import dcnd_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PAL   = 2'd2;
	localparam logic [1:0] ST_QUIET = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [PAL_AW-1:0] clr_q, clr_d;
	logic [2:0]        cnt_q, cnt_d;
	cmd_t              cur_q, cur_d;

	logic [7:0]        ctrl_q, ctrl_d;
	logic [2:0]        bank_q, bank_d;
	logic [3:0][7:0]   scroll_q, scroll_d;
	logic [7:0]        mcu_q, mcu_d;
	logic [7:0]        latch_q, latch_d;
	logic              nmi_en_q, nmi_en_d;
	logic              nmi_pend_q, nmi_pend_d;
	logic [7:0]        sw_a_q, sw_b_q, sw_c_q;

	logic              ram_we, ram_re;
	logic [PAL_AW-1:0] ram_wa, ram_ra;
	logic [15:0]       ram_wd, ram_rd;
	logic [15:0]       merged;

	logic              out_free;
	logic              emit;
	res_t              res;
	logic              out_valid_q;
	res_t              res_q;

	dcnd_ram #(
		.WIDTH(16),
		.DEPTH(PAL_ROWS)
	) u_pal (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en  (ram_re),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign clearing  = (state_q == ST_CLEAR);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		merged = ram_rd;
		if (cur_q.arg[0]) begin
			merged[15:8] = cur_q.data;
		end else begin
			merged[7:0] = cur_q.data;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		cnt_d      = cnt_q;
		cur_d      = cur_q;
		ctrl_d     = ctrl_q;
		bank_d     = bank_q;
		scroll_d   = scroll_q;
		mcu_d      = mcu_q;
		latch_d    = latch_q;
		nmi_en_d   = nmi_en_q;
		nmi_pend_d = nmi_pend_q;
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_wa     = clr_q;
		ram_wd     = '0;
		ram_re     = 1'b0;
		ram_ra     = q_cmd.arg[9:1];
		emit       = 1'b0;
		res        = '0;
		res.last_result = 1'b1;

		unique case (state_q)
			ST_CLEAR: begin
				// sweep the palette store to zero, one row a cycle
				ram_we = 1'b1;
				clr_d  = clr_q + PAL_AW'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid && out_free) begin
					pop   = 1'b1;
					cur_d = q_cmd;
					emit  = 1'b1;
					case (q_cmd.op) inside
						OP_PAL_WR, OP_PAL_RD: begin
							// fetch the byte pair, finish in ST_PAL once the result register is free
							emit    = 1'b0;
							ram_re  = 1'b1;
							state_d = ST_PAL;
						end
						OP_CTRL:   ctrl_d = q_cmd.data;
						OP_BANK:   bank_d = q_cmd.data[2:0];
						OP_SCROLL: scroll_d[q_cmd.arg[1:0]] = q_cmd.data;
						OP_MCU_WR: mcu_d = q_cmd.data;
						OP_LATCH_NMI: begin
							latch_d = q_cmd.data;
							if (nmi_en_q) begin
								res.sound_nmi = 1'b1;
							end else begin
								nmi_pend_d = 1'b1;
							end
						end
						OP_RD_IMM: res.read_value = q_cmd.data;
						OP_RD_MCU: begin
							res.read_value = ((mcu_q & MCU_MASK) == MCU_MASK) ?
								MCU_ANSWER : 8'd0;
						end
						OP_RD_SW: begin
							case (q_cmd.arg[1:0])
								CFG_SW_A: res.read_value = sw_a_q;
								CFG_SW_B: res.read_value = sw_b_q;
								CFG_SW_C: res.read_value = sw_c_q;
								default:  res.read_value = '0;
							endcase
						end
						OP_RD_SYS: begin
							// coin lockout masks at read time
							res.read_value = q_cmd.data &
								(ctrl_q[6] ? 8'hff : LOCKOUT_MASK);
						end
						OP_RD_LATCH: res.read_value = latch_q;
						OP_MSM: begin
							res.chip_kind     = KIND_MSM;
							res.chip_register = q_cmd.arg[3:0];
							res.chip_data     = q_cmd.data;
						end
						OP_AY, OP_AY_QUIET: begin
							res.chip_kind     = KIND_AY;
							res.chip_register = {2'd0, q_cmd.arg[1:0]};
							res.chip_data     = q_cmd.data;
							if (q_cmd.op == OP_AY_QUIET) begin
								res.last_result = 1'b0;
								cnt_d           = '0;
								state_d         = ST_QUIET;
							end
						end
						OP_SND_LATCH: latch_d = q_cmd.data;
						OP_NMI_EN: begin
							nmi_en_d = 1'b1;
							if (nmi_pend_q) begin
								res.sound_nmi = 1'b1;
								nmi_pend_d    = 1'b0;
							end
						end
						OP_NMI_DIS: nmi_en_d = 1'b0;
						default: ;
					endcase
				end
			end
			ST_PAL: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (cur_q.op == OP_PAL_WR) begin
						ram_we              = 1'b1;
						ram_wa              = cur_q.arg[9:1];
						ram_wd              = merged;
						res.palette_write   = 1'b1;
						res.palette_entry   = cur_q.arg[9:1];
						res.palette_color   = {merged[3:0], merged[15:8]};
					end else begin
						res.read_value = cur_q.arg[0] ? ram_rd[15:8] : ram_rd[7:0];
					end
				end
			end
			ST_QUIET: begin
				// zero the three volume registers of the addressed chip
				if (out_free) begin
					emit              = 1'b1;
					res.chip_kind     = KIND_AY;
					res.chip_register = {2'd0, cur_q.arg[1], cnt_q[0]};
					res.chip_data     = cnt_q[0] ? 8'd0 : (AY_VOL_REG + {6'd0, cnt_q[2:1]});
					res.last_result   = (cnt_q == QUIET_LAST);
					cnt_d             = cnt_q + 3'd1;
					if (cnt_q == QUIET_LAST) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase

		res.control_value = ctrl_d;
		res.program_bank  = bank_d;
		res.scroll_word   = scroll_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			ctrl_q      <= '0;
			bank_q      <= '0;
			scroll_q    <= '0;
			mcu_q       <= '0;
			latch_q     <= '0;
			nmi_en_q    <= 1'b0;
			nmi_pend_q  <= 1'b0;
			sw_a_q      <= SW_A_RESET;
			sw_b_q      <= SW_B_RESET;
			sw_c_q      <= SW_C_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			cnt_q      <= cnt_d;
			ctrl_q     <= ctrl_d;
			bank_q     <= bank_d;
			scroll_q   <= scroll_d;
			mcu_q      <= mcu_d;
			latch_q    <= latch_d;
			nmi_en_q   <= nmi_en_d;
			nmi_pend_q <= nmi_pend_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SW_A: sw_a_q <= cfg_data;
					CFG_SW_B: sw_b_q <= cfg_data;
					CFG_SW_C: sw_c_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (out_free && emit) begin
			res_q <= res;
		end
	end

endmodule

/* design/dual_cpu_io_latch_nmi_decoder.sv */
// Top level of the dual-processor I/O decoder: front decoder, command queue
// and back end. Depends on dcnd_pkg, dcnd_front, dcnd_queue, dcnd_back.
//
// Usage:
//  - s_axis carries one bus access per word; tuser gives the access kind
//    (main write, main read, sound write, sound read), tdata the address,
//    write byte and the five live player ports.
//  - m_axis returns the results of each access; tlast marks the final word
//    of an access. Most accesses give one word, an AY write of 0x88 gives
//    seven (the write, then three volume registers zeroed).
//  - cfg writes load the three switch banks; cfg_ready is always high.
// Register, port and sound chip accesses finish in the back end's idle
// state; palette accesses use the registered read of the palette RAM,
// before the merge and write-back of a write; the AY silencing burst gives
// one chip write per cycle while the result register is free. A two-word
// queue lets the front keep accepting while the back works, and the result
// register holds while m_axis_tready is low, stalling the back end and then
// the queue. Reset: registers take their reset values, then the palette RAM
// is cleared one row a cycle, with s_axis_tready held low meanwhile.
module dual_cpu_io_latch_nmi_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] bus_address, [23:16] bus_data, [31:24] port_system,
	// [39:32] port_stick_one, [47:40] port_buttons_one,
	// [55:48] port_stick_two, [63:56] port_buttons_two
	input  logic [63:0] s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] read_value, [8] sound_nmi, [17:9] palette_entry,
	// [29:18] palette_color, [37:30] control_value, [40:38] program_bank,
	// [72:41] scroll_word, [76:73] chip_register, [84:77] chip_data, rest zero
	output logic [87:0] m_axis_tdata,
	// [0] palette_write, [2:1] chip_kind
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import dcnd_pkg::*;

	logic q_ready;
	logic q_valid;
	logic push;
	logic pop;
	logic clearing;
	cmd_t push_cmd;
	cmd_t head_cmd;
	res_t res;

	assign cfg_ready = 1'b1;

	dcnd_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_ready      (q_ready),
		.clearing     (clearing),
		.push         (push),
		.cmd          (push_cmd)
	);

	dcnd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.ready   (q_ready),
		.pop     (pop),
		.valid   (q_valid),
		.head    (head_cmd)
	);

	dcnd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (head_cmd),
		.pop      (pop),
		.clearing (clearing),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_res  (res)
	);

	assign m_axis_tdata = {3'd0, res.chip_data, res.chip_register, res.scroll_word,
		res.program_bank, res.control_value, res.palette_color, res.palette_entry,
		res.sound_nmi, res.read_value};
	assign m_axis_tuser = {res.chip_kind, res.palette_write};
	assign m_axis_tlast = res.last_result;

endmodule

/* test/dcnd_access_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the dual-processor bus decoder: watches the access, result and
// switch-write channels, predicts every result word and compares it.
// Depends on dcnd_pkg for codes, bus map and the result layout.
module dcnd_access_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [87:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending_count
);
	import dcnd_pkg::*;

	logic [7:0] pal_mem [1024];
	logic [7:0] scroll_q [4];
	logic [7:0] ctrl_reg;
	logic [2:0] bank_reg;
	logic [7:0] mcu_reg;
	logic [7:0] latch_reg;
	logic       nmi_en;
	logic       nmi_pend;
	logic [7:0] sw_a, sw_b, sw_c;
	res_t       expected_words [$];
	int         errors = 0;

	task automatic report_error(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	task automatic clear_model();
		foreach (pal_mem[i]) pal_mem[i] = 8'h00;
		foreach (scroll_q[i]) scroll_q[i] = 8'h00;
		ctrl_reg  = 8'h00;
		bank_reg  = 3'd0;
		mcu_reg   = 8'h00;
		latch_reg = 8'h00;
		nmi_en    = 1'b0;
		nmi_pend  = 1'b0;
		sw_a      = SW_A_RESET;
		sw_b      = SW_B_RESET;
		sw_c      = SW_C_RESET;
	endtask

	// Work out the result words of one access and queue them.
	task automatic decode_access(input logic [1:0] mode, input logic [15:0] addr,
			input logic [7:0] data, input logic [39:0] ports);
		res_t r;
		logic [9:0] idx;
		logic quiet;
		int k;
		r = '0;
		quiet = 1'b0;
		idx = addr[9:0];
		case (mode)
			MODE_MAIN_WR: begin
				if (addr[15:10] == ADDR_PAL[15:10]) begin
					pal_mem[idx] = data;
					r.palette_write = 1'b1;
					r.palette_entry = idx[9:1];
					r.palette_color = {pal_mem[{idx[9:1], 1'b0}][3:0],
						pal_mem[{idx[9:1], 1'b1}]};
				end else if (addr == ADDR_CTRL) begin
					ctrl_reg = data;
				end else if (addr == ADDR_BANK) begin
					bank_reg = data[2:0];
				end else if (addr[15:2] == ADDR_SCROLL[15:2]) begin
					scroll_q[addr[1:0]] = data;
				end else if (addr == ADDR_MCU) begin
					mcu_reg = data;
				end else if (addr == ADDR_LATCH) begin
					latch_reg = data;
					if (nmi_en)
						r.sound_nmi = 1'b1;
					else
						nmi_pend = 1'b1;
				end
			end
			MODE_MAIN_RD: begin
				k = int'(addr) - int'(ADDR_SWITCH);
				if (addr[15:10] == ADDR_PAL[15:10])
					r.read_value = pal_mem[idx];
				else if (addr == ADDR_MCU)
					r.read_value = ((mcu_reg & MCU_MASK) == MCU_MASK) ? MCU_ANSWER : 8'h00;
				else if (addr == ADDR_MCU_ST)
					r.read_value = MCU_STATUS;
				else if (k == 0)
					r.read_value = sw_a;
				else if (k == 1)
					r.read_value = sw_b;
				else if (k == 2)
					r.read_value = sw_c;
				else if (k == 3)
					// coin lockout masks the system port at read time
					r.read_value = ports[7:0] & (ctrl_reg[6] ? 8'hff : LOCKOUT_MASK);
				else if (k >= 4 && k <= 7)
					r.read_value = ports[(k - 3) * 8 +: 8];
				else if (addr == ADDR_LATCH)
					r.read_value = latch_reg;
			end
			MODE_SND_WR: begin
				if (addr[15:4] == ADDR_MSM[15:4]) begin
					r.chip_kind     = KIND_MSM;
					r.chip_register = addr[3:0];
					r.chip_data     = data;
				end else if (addr[15:2] == ADDR_AY[15:2]) begin
					r.chip_kind     = KIND_AY;
					r.chip_register = {2'b00, addr[1:0]};
					r.chip_data     = data;
					quiet = (data == AY_QUIET_KEY);
				end else if (addr == ADDR_SND_LAT) begin
					latch_reg = data;
				end else if (addr == ADDR_NMI_EN) begin
					nmi_en = 1'b1;
					if (nmi_pend) begin
						r.sound_nmi = 1'b1;
						nmi_pend = 1'b0;
					end
				end else if (addr == ADDR_NMI_DIS) begin
					nmi_en = 1'b0;
				end
			end
			default: begin
				if (addr == ADDR_SND_LAT)
					r.read_value = latch_reg;
			end
		endcase
		r.control_value = ctrl_reg;
		r.program_bank  = bank_reg;
		r.scroll_word   = {scroll_q[3], scroll_q[2], scroll_q[1], scroll_q[0]};
		r.last_result   = !quiet;
		expected_words.push_back(r);
		if (quiet) begin
			// zero volume registers 8, 9, 10 as address/data pairs on the same chip
			for (int i = 0; i < 6; i++) begin
				r.chip_register = {2'b00, addr[1], i[0]};
				r.chip_data     = i[0] ? 8'h00 : AY_VOL_REG + 8'(i >> 1);
				r.last_result   = (i == int'(QUIET_LAST));
				expected_words.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			clear_model();
			expected_words.delete();
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.read_value    = m_axis_tdata[7:0];
				got.sound_nmi     = m_axis_tdata[8];
				got.palette_entry = m_axis_tdata[17:9];
				got.palette_color = m_axis_tdata[29:18];
				got.control_value = m_axis_tdata[37:30];
				got.program_bank  = m_axis_tdata[40:38];
				got.scroll_word   = m_axis_tdata[72:41];
				got.chip_register = m_axis_tdata[76:73];
				got.chip_data     = m_axis_tdata[84:77];
				got.palette_write = m_axis_tuser[0];
				got.chip_kind     = m_axis_tuser[2:1];
				got.last_result   = m_axis_tlast;
				if (expected_words.size() == 0) begin
					report_error("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					compare_field("read_value", 32'(got.read_value),
						32'(want.read_value));
					compare_field("sound_nmi", 32'(got.sound_nmi), 32'(want.sound_nmi));
					compare_field("palette_write", 32'(got.palette_write),
						32'(want.palette_write));
					compare_field("palette_entry", 32'(got.palette_entry),
						32'(want.palette_entry));
					compare_field("palette_color", 32'(got.palette_color),
						32'(want.palette_color));
					compare_field("control_value", 32'(got.control_value),
						32'(want.control_value));
					compare_field("program_bank", 32'(got.program_bank),
						32'(want.program_bank));
					compare_field("scroll_word", got.scroll_word, want.scroll_word);
					compare_field("chip_kind", 32'(got.chip_kind), 32'(want.chip_kind));
					compare_field("chip_register", 32'(got.chip_register),
						32'(want.chip_register));
					compare_field("chip_data", 32'(got.chip_data), 32'(want.chip_data));
					compare_field("last_result", 32'(got.last_result),
						32'(want.last_result));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SW_A: sw_a = cfg_data;
					CFG_SW_B: sw_b = cfg_data;
					CFG_SW_C: sw_c = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
					s_axis_tdata[63:24]);
			pending_count <= expected_words.size();
			fail_count <= errors;
		end
	end

endmodule

/* test/tb_dual_cpu_io_latch_nmi_decoder.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the dual-processor bus decoder: directed accesses,
// random access sequences under several switch settings, stalls on both sides.
// Depends on dcnd_pkg, the decoder RTL and dcnd_access_checker.
module tb_dual_cpu_io_latch_nmi_decoder;
	import dcnd_pkg::*;

	localparam int STALL_LIMIT      = 5000;
	localparam int SINK_HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = MODE_MAIN_WR;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SW_A;
	logic [7:0]  cfg_data = 8'h00;

	int   fail_count;
	int   pending_count;
	int   items_sent = 0;
	int   stall_cycles = 0;
	int   sink_hold_req = 0;
	int   sink_hold_seen = 0;
	int   sink_hold_left = 0;
	logic steady = 1'b0;

	dual_cpu_io_latch_nmi_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	dcnd_access_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result sink: random back-pressure, or a long hold-off when asked
	always @(posedge clk) begin
		if (sink_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_left <= sink_hold_left - 1;
		end else if (sink_hold_req != sink_hold_seen) begin
			sink_hold_seen <= sink_hold_req;
			sink_hold_left <= SINK_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 22);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [39:0] random_ports();
		return {8'($urandom), $urandom};
	endfunction

	function automatic logic [15:0] pick_address();
		case ($urandom_range(0, 11))
			0: return ADDR_PAL | 16'($urandom_range(0, 1023));
			1: return ADDR_CTRL;
			2: return ADDR_BANK;
			3: return ADDR_SCROLL + 16'($urandom_range(0, 3));
			4: return ADDR_MCU + 16'($urandom_range(0, 1));
			5: return ADDR_SWITCH + 16'($urandom_range(0, 7));
			6: return ADDR_LATCH;
			7: return ADDR_MSM | 16'($urandom_range(0, 15));
			8: return ADDR_AY + 16'($urandom_range(0, 7));
			9: return ADDR_SND_LAT;
			10: return 16'h d000 | 16'($urandom_range(0, 16'h0fff));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 7))
			0: return AY_QUIET_KEY;
			1: return 8'($urandom) | MCU_MASK;
			2: return 8'h00;
			3: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one access word after a random gap and hold it until taken.
	task automatic send_access(input logic [1:0] mode, input logic [15:0] addr,
			input logic [7:0] data, input logic [39:0] ports);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(0, 99) < 22 && gap < 12)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {ports, data, addr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait until every expected word has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic load_switches(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] vals [3];
		logic [1:0] regs [3];
		vals = '{a, b, c};
		regs = '{CFG_SW_A, CFG_SW_B, CFG_SW_C};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random access sequences, mostly well-formed, until the item count is reached.
	task automatic run_mix(input int target);
		logic [15:0] addr;
		logic [7:0] data;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				4: begin
					addr = ADDR_PAL | (16'($urandom_range(0, 511)) << 1);
					send_access(MODE_MAIN_WR, addr, pick_data(), random_ports());
					send_access(MODE_MAIN_WR, addr + 16'd1, pick_data(), random_ports());
					send_access(MODE_MAIN_RD, addr + 16'($urandom_range(0, 1)), 8'($urandom),
						random_ports());
				end
				5: begin
					send_access(MODE_MAIN_WR, ADDR_LATCH, pick_data(), random_ports());
					if ($urandom_range(0, 1))
						send_access(MODE_SND_WR, ADDR_NMI_DIS, pick_data(), random_ports());
					send_access(MODE_SND_WR, ADDR_NMI_EN, pick_data(), random_ports());
					send_access(MODE_SND_RD, ADDR_SND_LAT, pick_data(), random_ports());
					send_access(MODE_MAIN_RD, ADDR_LATCH, pick_data(), random_ports());
				end
				6: begin
					send_access(MODE_SND_WR, ADDR_AY + 16'($urandom_range(0, 3)), AY_QUIET_KEY,
						random_ports());
					send_access(MODE_SND_WR, ADDR_MSM | 16'($urandom_range(0, 15)),
						pick_data(), random_ports());
				end
				7: begin
					send_access(MODE_MAIN_WR, ADDR_CTRL, pick_data(), random_ports());
					send_access(MODE_MAIN_RD, ADDR_SWITCH + 16'd3, pick_data(), random_ports());
				end
				8: begin
					data = $urandom_range(0, 1) ? (8'($urandom) | MCU_MASK) : 8'($urandom);
					send_access(MODE_MAIN_WR, ADDR_MCU, data, random_ports());
					send_access(MODE_MAIN_RD, ADDR_MCU, pick_data(), random_ports());
				end
				9: send_access(2'($urandom), 16'($urandom), 8'($urandom), random_ports());
				default: send_access(2'($urandom), pick_address(), pick_data(), random_ports());
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// switches at reset values, lockout, player ports, palette pair, registers
		send_access(MODE_MAIN_RD, ADDR_SWITCH, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_SWITCH + 16'd1, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_SWITCH + 16'd2, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_SWITCH + 16'd3, 8'h00, 40'hff_ffff_ffff);
		send_access(MODE_MAIN_WR, ADDR_CTRL, 8'h40, random_ports());
		send_access(MODE_MAIN_RD, ADDR_SWITCH + 16'd3, 8'h00, 40'hff_ffff_ffff);
		send_access(MODE_MAIN_RD, ADDR_PLAYER, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_PLAYER + 16'd3, 8'h00, random_ports());
		send_access(MODE_MAIN_WR, ADDR_PAL, 8'hff, random_ports());
		send_access(MODE_MAIN_WR, ADDR_PAL + 16'd1, 8'ha5, random_ports());
		send_access(MODE_MAIN_WR, ADDR_PAL + 16'h3ff, 8'h3c, random_ports());
		send_access(MODE_MAIN_RD, ADDR_PAL + 16'h3ff, 8'h00, random_ports());
		send_access(MODE_MAIN_WR, ADDR_BANK, 8'hff, random_ports());
		send_access(MODE_MAIN_WR, ADDR_SCROLL + 16'd3, 8'hff, random_ports());
		send_access(MODE_MAIN_WR, ADDR_MCU, MCU_MASK, random_ports());
		send_access(MODE_MAIN_RD, ADDR_MCU, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_MCU_ST, 8'h00, random_ports());
		// latch while NMI disabled goes pending, enabling then fires it
		send_access(MODE_MAIN_WR, ADDR_LATCH, 8'h5a, random_ports());
		send_access(MODE_SND_RD, ADDR_SND_LAT, 8'h00, random_ports());
		send_access(MODE_SND_WR, ADDR_NMI_EN, 8'h00, random_ports());
		send_access(MODE_MAIN_WR, ADDR_LATCH, 8'h77, random_ports());
		send_access(MODE_SND_WR, ADDR_NMI_DIS, 8'h00, random_ports());
		send_access(MODE_MAIN_RD, ADDR_LATCH, 8'h00, random_ports());
		send_access(MODE_SND_WR, ADDR_AY + 16'd3, AY_QUIET_KEY, random_ports());
		send_access(MODE_SND_WR, ADDR_MSM + 16'hf, 8'hff, random_ports());
		send_access(MODE_SND_WR, ADDR_SND_LAT, 8'h00, random_ports());
		send_access(MODE_MAIN_WR, 16'hffff, 8'hff, random_ports());
		send_access(MODE_MAIN_RD, 16'h0000, 8'h00, random_ports());

		drain();
		load_switches(8'hff, 8'hff, 8'hff);
		run_mix(items_sent + 60);

		drain();
		load_switches(8'h00, 8'h00, 8'h00);
		steady <= 1'b1;
		run_mix(items_sent + 40);
		steady <= 1'b0;

		// hold the sink off while words keep coming, so the input stalls
		drain();
		load_switches(8'($urandom), 8'($urandom), 8'($urandom));
		steady <= 1'b1;
		sink_hold_req <= sink_hold_req + 1;
		run_mix(items_sent + 20);
		steady <= 1'b0;
		run_mix(items_sent + 60);

		drain();
		load_switches(8'($urandom), 8'($urandom), 8'($urandom));
		run_mix(items_sent + 30);
		drain();
		run_mix(items_sent + 30);

		drain();
		load_switches(SW_A_RESET, SW_B_RESET, SW_C_RESET);
		run_mix(items_sent + 60);

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
design/dcnd_pkg.sv
design/dcnd_ram.sv
design/dcnd_front.sv
design/dcnd_queue.sv
design/dcnd_back.sv
design/dual_cpu_io_latch_nmi_decoder.sv
test/dcnd_access_checker.sv
test/tb_dual_cpu_io_latch_nmi_decoder.sv
